[hdl/rte_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the radix table encoder.
// No dependencies; used by rte_slicer and radix_table_encoder_unit.
package rte_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int BYTE_BITS       = 8;
    localparam int BUF_W           = 15;
    localparam int CNT_W           = 4;
    localparam int IDX_W           = 8;
    localparam int CHAR_W          = 8;
    localparam int CFG_W           = 4;

    localparam logic [CFG_W-1:0] SYMBOL_BITS_RESET = 4'd6;
    localparam logic [CFG_W-1:0] SYMBOL_BITS_MIN   = 4'd1;
    localparam logic [CFG_W-1:0] SYMBOL_BITS_MAX   = 4'd8;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_ENCODE = 1'b1;

    // one table read request from the slicer
    typedef struct packed {
        logic              vld;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_grp_req;

    // clamp the register to a legal group width
    function automatic logic [CNT_W-1:0] group_width(input logic [CFG_W-1:0] bits);
        logic [CNT_W-1:0] w;
        if (bits < SYMBOL_BITS_MIN) begin
            w = SYMBOL_BITS_MIN;
        end else if (bits > SYMBOL_BITS_MAX) begin
            w = SYMBOL_BITS_MAX;
        end else begin
            w = bits;
        end
        return w;
    endfunction

endpackage

[hdl/rte_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Read-before-write on an address collision. No dependencies.
module rte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/rte_slicer.sv]
`timescale 1ns / 1ps
// Bit buffer that cuts the byte stream into groups, one table read per cycle while i_adv is high.
// Depends on rte_pkg.
module rte_slicer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic [rte_pkg::CNT_W-1:0]     i_width,
    input  logic                          i_adv,
    input  logic                          i_take,
    input  logic [rte_pkg::BYTE_BITS-1:0] i_byte,
    input  logic                          i_last,
    output logic                          o_room,
    output rte_pkg::t_grp_req             o_req
);

    logic [rte_pkg::BUF_W-1:0] r_buf, n_buf;
    logic [rte_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_last, n_last;

    logic                      pending, issue, final_grp;
    logic [rte_pkg::CNT_W-1:0] shift, cur_cnt;
    logic [rte_pkg::BUF_W-1:0] grp_mask, rem_mask, grp_bits, rem_buf, cur_buf;
    logic                      cur_last;

    always_comb begin
        pending   = (r_cnt >= i_width);
        shift     = r_cnt - i_width;
        grp_mask  = ~(15'h7FFF << i_width);
        rem_mask  = ~(15'h7FFF << shift);
        grp_bits  = (r_buf >> shift) & grp_mask;
        rem_buf   = r_buf & rem_mask;
        final_grp = (shift < i_width);
        issue     = pending && i_adv;

        if (issue) begin
            cur_cnt  = (final_grp && r_last) ? '0 : shift;
            cur_buf  = (final_grp && r_last) ? '0 : rem_buf;
            cur_last = r_last && !final_grp;
        end else begin
            cur_cnt  = r_cnt;
            cur_buf  = r_buf;
            cur_last = r_last;
        end

        if (i_clear) begin
            n_buf  = '0;
            n_cnt  = '0;
            n_last = 1'b0;
        end else if (i_take) begin
            // pending bits stay below the group width, so seven of them suffice
            n_buf  = {cur_buf[rte_pkg::BUF_W-rte_pkg::BYTE_BITS-1:0], i_byte};
            n_cnt  = cur_cnt + rte_pkg::CNT_W'(rte_pkg::BYTE_BITS);
            n_last = i_last;
        end else begin
            n_buf  = cur_buf;
            n_cnt  = cur_cnt;
            n_last = cur_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_cnt  <= '0;
            r_last <= 1'b0;
        end else begin
            r_buf  <= n_buf;
            r_cnt  <= n_cnt;
            r_last <= n_last;
        end
    end

    assign o_room     = !pending || (issue && final_grp);
    assign o_req.vld  = issue;
    assign o_req.idx  = grp_bits[rte_pkg::IDX_W-1:0];
    assign o_req.last = final_grp && r_last;

endmodule

[hdl/radix_table_encoder_unit.sv]
`timescale 1ns / 1ps
// Radix table encoder: byte stream to table symbols, 1..8 bits per symbol.
// A symbol passes through the table read stage and then the output register.
// Throughput: one symbol per cycle while the output is not stalled; a byte yields 1 to 8
// symbols, one per completed group, through the single read port of the character table RAM.
// Reset: bit buffer empty, symbol_bits = 6; the table RAM is not cleared.
// Depends on rte_pkg, rte_ram, rte_slicer.
module radix_table_encoder_unit #(
    parameter int TABLE_DEPTH = rte_pkg::DEF_TABLE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write channel (symbol_bits)
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rte_pkg::CFG_W-1:0]   i_cfg_data,
    // input requests
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_command,
    input  logic [rte_pkg::IDX_W-1:0]   i_table_index,
    input  logic [rte_pkg::CHAR_W-1:0]  i_table_char,
    input  logic [rte_pkg::BYTE_BITS-1:0] i_data_byte,
    input  logic                        i_last_byte,
    // output symbols
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [rte_pkg::CHAR_W-1:0]  o_symbol,
    output logic                        o_last_symbol
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // config register
    logic [rte_pkg::CFG_W-1:0] r_symbol_bits;
    logic                      cfg_wr;
    logic [rte_pkg::CNT_W-1:0] width;

    // request decode
    logic              in_acc, load_acc, data_acc, tbl_we;
    logic              room;
    rte_pkg::t_grp_req req;

    // read stage and output register
    logic                       r_s1_valid, r_s1_oob, r_s1_last;
    logic                       r_out_valid, r_out_last;
    logic [rte_pkg::CHAR_W-1:0] r_out_symbol;
    logic [rte_pkg::CHAR_W-1:0] ram_rdata;
    logic                       out_free, adv, req_oob;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign width       = rte_pkg::group_width(r_symbol_bits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_bits <= rte_pkg::SYMBOL_BITS_RESET;
        end else if (cfg_wr) begin
            r_symbol_bits <= i_cfg_data;
        end
    end

    // Loads and bytes share one ready: a load waits until the previous byte's
    // last group is issued, so its table write never overtakes an older read.
    // A write in the same cycle as that read is safe: the RAM reads first.
    assign o_in_ready = room;
    assign in_acc     = i_in_valid && o_in_ready;
    assign load_acc   = in_acc && (i_command == rte_pkg::CMD_LOAD);
    assign data_acc   = in_acc && (i_command == rte_pkg::CMD_ENCODE);
    assign tbl_we     = load_acc && ({1'b0, i_table_index} < 9'(TABLE_DEPTH));

    // pipeline advance: output register frees, read stage moves on
    assign out_free = !r_out_valid || i_out_ready;
    assign adv      = !r_s1_valid || out_free;
    assign req_oob  = ({1'b0, req.idx} >= 9'(TABLE_DEPTH));

    rte_slicer u_slicer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (cfg_wr),
        .i_width (width),
        .i_adv   (adv),
        .i_take  (data_acc),
        .i_byte  (i_data_byte),
        .i_last  (i_last_byte),
        .o_room  (room),
        .o_req   (req)
    );

    // character table; read data holds while the read stage is stalled
    rte_ram #(
        .WIDTH (rte_pkg::CHAR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (i_table_index[AW-1:0]),
        .i_wdata (i_table_char),
        .i_re    (req.vld),
        .i_raddr (req.idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= req.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_oob  <= req_oob;
            r_s1_last <= req.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // groups past the table end read as zero
    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_symbol <= r_s1_oob ? '0 : ram_rdata;
            r_out_last   <= r_s1_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_symbol      = r_out_symbol;
    assign o_last_symbol = r_out_last;

    // no new read while a fetched symbol is parked in the read stage
    a_no_read_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |-> !req.vld)
        else $error("table read issued over a stalled read stage");

    // a width change restarts on an empty buffer
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> !req.vld)
        else $error("group issued right after a configuration write");

    // a fetched symbol reaches the output register when it has room
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && out_free) |=> o_out_valid)
        else $error("fetched symbol lost between read stage and output");

endmodule
